### rtl/layered_nitrate_leach_step_macros.svh
// Assertion macros used by the top-level RTL.
`ifndef LAYERED_NITRATE_LEACH_STEP_MACROS_SVH
`define LAYERED_NITRATE_LEACH_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define LNLS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define LNLS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define LNLS_ASSERT_IMP(lbl, ante, cons)
`define LNLS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/lnls_pkg.sv
`default_nettype none
package lnls_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int NITRATE_WIDTH = 32;
   localparam int FLUX_W        = 24;
   localparam int CRIT_W        = FLUX_W - 1;
   localparam int FRAC_REG_W    = FRAC_BITS + 1;
   localparam int STREAM_W      = 40;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = CRIT_W;

   // divider: quotient bits FRAC_BITS..0 plus leading pad bits, DIV_UNROLL per cycle
   localparam int DIV_UNROLL    = 6;
   localparam int DIV_CYCLES    = (FRAC_BITS + 1 + DIV_UNROLL - 1) / DIV_UNROLL;
   localparam int DIV_QW        = DIV_CYCLES * DIV_UNROLL;
   localparam int DIV_PRE       = DIV_QW - FRAC_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_CYCLES + 1);

   localparam logic [FRAC_REG_W-1:0]    ONE_FRAC        = FRAC_REG_W'(1) << FRAC_BITS;
   localparam logic [CRIT_W-1:0]        CRIT_FLOW_RESET = CRIT_W'(1) << FRAC_BITS;
   localparam logic [NITRATE_WIDTH-1:0] NIT_MAX         = '1;
   localparam logic [STREAM_W-1:0]      STREAM_MAX      = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CRIT_FLOW      = 2'd0,
      CSR_LEACH_FRACTION = 2'd1,
      CSR_STORM_FRACTION = 2'd2,
      CSR_BASE_FRACTION  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_LEACH = 2'd0,
      MUL_INTEN = 2'd1,
      MUL_STORM = 2'd2,
      MUL_BASE  = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic signed [FLUX_W-1:0]   water_flux;
      logic [NITRATE_WIDTH-1:0]   layer_nitrate;
      logic [NITRATE_WIDTH-1:0]   below_nitrate;
      logic                       is_last;
   } req_payload_type;

   typedef struct packed {
      logic [NITRATE_WIDTH-1:0]   new_layer_nitrate;
      logic [NITRATE_WIDTH-1:0]   new_below_nitrate;
      logic [NITRATE_WIDTH-1:0]   leached_total;
      logic [STREAM_W-1:0]        stream_total;
      logic                       result_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [CRIT_W-1:0]          crit_flow;
      logic [FRAC_REG_W-1:0]      leach_fraction;
      logic [FRAC_REG_W-1:0]      storm_fraction;
      logic [FRAC_REG_W-1:0]      base_fraction;
   } cfg_type;

   typedef struct packed {
      logic        load;
      logic        div_step;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        stage_amt;
      logic        move;
      logic        pool;
      logic        sum;
      logic        finish;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
   } dp_sts_type;

   function automatic logic [FRAC_REG_W-1:0] clamp_frac(input logic [FRAC_REG_W-1:0] f);
      return (f > ONE_FRAC) ? ONE_FRAC : f;
   endfunction

endpackage
`default_nettype wire

### rtl/layered_nitrate_leach_step.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_payload (one soil layer)
// rsp_      out        rsp_valid / rsp_ready  rsp_payload (layer result)
// csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// Upper layer: DIV, AMT, STORM, MOVE, FINISH; the bottom layer adds POOL, BASE, SUM.
// Divider: 6 quotient bits per cycle. Products: the single shared 32x17 multiplier.
// Synchronous reset clears carry-down and the stream total and sets the CSRs to defaults.
// A result waits in the output register while the next transaction is taken;
// a following result waits in the final step until that register is free.
`default_nettype none
`include "layered_nitrate_leach_step_macros.svh"
module layered_nitrate_leach_step (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  lnls_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output lnls_pkg::rsp_payload_type            rsp_payload,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lnls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lnls_pkg::CSR_DATA_W-1:0] csr_data
);
   import lnls_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   dp_cmd_type      cmd;
   dp_sts_type      sts;
   rsp_payload_type result;
   logic            out_free;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_CRIT_FLOW:      cfg_in.crit_flow      = csr_data[CRIT_W-1:0];
            CSR_LEACH_FRACTION: cfg_in.leach_fraction = csr_data[FRAC_REG_W-1:0];
            CSR_STORM_FRACTION: cfg_in.storm_fraction = csr_data[FRAC_REG_W-1:0];
            CSR_BASE_FRACTION:  cfg_in.base_fraction  = csr_data[FRAC_REG_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crit_flow      <= CRIT_FLOW_RESET;
         cfg_ff.leach_fraction <= '0;
         cfg_ff.storm_fraction <= '0;
         cfg_ff.base_fraction  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   lnls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .sts       (sts),
      .cmd       (cmd)
   );

   lnls_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg_ff),
      .req_payload (req_payload),
      .sts         (sts),
      .result      (result)
   );

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (cmd.finish) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `LNLS_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `LNLS_ASSERT_IMP(a_rsp_from_finish, $rose(rsp_valid), $past(cmd.finish))
   `LNLS_ASSERT_IMP(a_upper_no_loss, rsp_valid && !rsp_payload.result_last, (rsp_payload.leached_total == '0) && (rsp_payload.new_below_nitrate == '0))

endmodule
`default_nettype wire

### rtl/lnls_ctrl.sv
`default_nettype none
module lnls_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 out_free,
   input  lnls_pkg::dp_sts_type      sts,
   output lnls_pkg::dp_cmd_type      cmd
);
   import lnls_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DIV    = 9'b000000010,
      ST_AMT    = 9'b000000100,
      ST_STORM  = 9'b000001000,
      ST_MOVE   = 9'b000010000,
      ST_POOL   = 9'b000100000,
      ST_BASE   = 9'b001000000,
      ST_SUM    = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_LEACH;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_LEACH;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_AMT;
            end
         end
         ST_AMT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_INTEN;
            state_in    = ST_STORM;
         end
         ST_STORM: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_STORM;
            cmd.stage_amt = 1'b1;
            state_in      = ST_MOVE;
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = sts.last ? ST_POOL : ST_FINISH;
         end
         ST_POOL: begin
            cmd.pool = 1'b1;
            state_in = ST_BASE;
         end
         ST_BASE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_BASE;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### rtl/lnls_dp.sv
`default_nettype none
module lnls_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  lnls_pkg::dp_cmd_type      cmd,
   input  lnls_pkg::cfg_type         cfg,
   input  lnls_pkg::req_payload_type req_payload,
   output lnls_pkg::dp_sts_type      sts,
   output lnls_pkg::rsp_payload_type result
);
   import lnls_pkg::*;

   localparam int NW = NITRATE_WIDTH;
   localparam int MW = NW + FRAC_REG_W;

   // payload
   logic [NW-1:0]         n_ff, n_in;
   logic [NW-1:0]         below_ff, below_in;
   logic [NW-1:0]         prod_ff, prod_in;
   logic [NW-1:0]         amt_ff, amt_in;
   logic [NW-1:0]         strm_ff, strm_in;
   logic [NW-1:0]         moved_ff, moved_in;
   logic [NW-1:0]         loss_ff, loss_in;
   logic [CRIT_W-1:0]     rem_ff, rem_in;
   logic [DIV_QW-1:0]     dbits_ff, dbits_in;
   logic [DIV_QW-1:0]     quot_ff, quot_in;
   logic                  last_ff, last_in;
   logic                  flux_pos_ff, flux_pos_in;
   logic                  ovf_ff, ovf_in;
   // state
   logic [NW-1:0]         carry_ff, carry_in;
   logic [STREAM_W-1:0]   acc_ff, acc_in;

   logic [FLUX_W-2:0]     flux_mag;
   logic [NW:0]           n_sum;
   logic [CRIT_W-1:0]     rem_v;
   logic [DIV_QW-1:0]     dbits_v;
   logic [DIV_QW-1:0]     quot_v;
   logic [CRIT_W:0]       trial;
   logic [FRAC_REG_W-1:0] inten;
   logic [NW-1:0]         mul_a;
   logic [FRAC_REG_W-1:0] mul_b;
   logic [MW-1:0]         mul_full;
   logic [NW:0]           pool_sum;
   logic [NW:0]           loss_sum;
   logic [STREAM_W:0]     acc_sum;
   logic [STREAM_W-1:0]   acc_next;

   assign flux_mag = req_payload.water_flux[FLUX_W-2:0];
   assign n_sum    = {1'b0, req_payload.layer_nitrate} + {1'b0, carry_ff};

   always_comb begin
      rem_v   = rem_ff;
      dbits_v = dbits_ff;
      quot_v  = quot_ff;
      trial   = '0;
      for (int i = 0; i < DIV_UNROLL; i++) begin
         trial   = {rem_v, dbits_v[DIV_QW-1]};
         dbits_v = dbits_v << 1;
         if (trial >= {1'b0, cfg.crit_flow}) begin
            rem_v  = CRIT_W'(trial - {1'b0, cfg.crit_flow});
            quot_v = {quot_v[DIV_QW-2:0], 1'b1};
         end else begin
            rem_v  = trial[CRIT_W-1:0];
            quot_v = {quot_v[DIV_QW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (!(flux_pos_ff && (n_ff != '0))) begin
         inten = '0;
      end else if (ovf_ff || (quot_ff > DIV_QW'(ONE_FRAC))) begin
         inten = ONE_FRAC;
      end else begin
         inten = quot_ff[FRAC_REG_W-1:0];
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         MUL_LEACH: begin
            mul_a = n_ff;
            mul_b = clamp_frac(cfg.leach_fraction);
         end
         MUL_INTEN: begin
            mul_a = prod_ff;
            mul_b = inten;
         end
         MUL_STORM: begin
            mul_a = prod_ff;
            mul_b = last_ff ? clamp_frac(cfg.storm_fraction) : '0;
         end
         MUL_BASE: begin
            mul_a = below_ff;
            mul_b = clamp_frac(cfg.base_fraction);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = {{FRAC_REG_W{1'b0}}, mul_a} * {{NW{1'b0}}, mul_b};

   assign pool_sum = {1'b0, below_ff} + {1'b0, moved_ff};
   assign loss_sum = {1'b0, strm_ff} + {1'b0, prod_ff};
   assign acc_sum  = {1'b0, acc_ff} + (STREAM_W + 1)'(loss_ff);
   assign acc_next = !last_ff ? acc_ff :
                     (acc_sum[STREAM_W] ? STREAM_MAX : acc_sum[STREAM_W-1:0]);

   always_comb begin
      n_in        = n_ff;
      below_in    = below_ff;
      prod_in     = prod_ff;
      amt_in      = amt_ff;
      strm_in     = strm_ff;
      moved_in    = moved_ff;
      loss_in     = loss_ff;
      rem_in      = rem_ff;
      dbits_in    = dbits_ff;
      quot_in     = quot_ff;
      last_in     = last_ff;
      flux_pos_in = flux_pos_ff;
      ovf_in      = ovf_ff;
      carry_in    = carry_ff;
      acc_in      = acc_ff;

      if (cmd.load) begin
         n_in        = n_sum[NW] ? NIT_MAX : n_sum[NW-1:0];
         below_in    = req_payload.below_nitrate;
         last_in     = req_payload.is_last;
         loss_in     = '0;
         moved_in    = '0;
         flux_pos_in = (req_payload.water_flux != '0) && !req_payload.water_flux[FLUX_W-1];
         ovf_in      = {1'b0, flux_mag} >= {cfg.crit_flow, 1'b0};
         rem_in      = CRIT_W'(flux_mag >> DIV_PRE);
         dbits_in    = {flux_mag[DIV_PRE-1:0], {FRAC_BITS{1'b0}}};
         quot_in     = '0;
      end
      if (cmd.div_step) begin
         rem_in   = rem_v;
         dbits_in = dbits_v;
         quot_in  = quot_v;
      end
      if (cmd.mul_en) begin
         prod_in = mul_full[FRAC_BITS +: NW];
      end
      if (cmd.stage_amt) begin
         amt_in = prod_ff;
      end
      if (cmd.move) begin
         strm_in = prod_ff;
         if (amt_ff < n_ff) begin
            n_in     = n_ff - amt_ff;
            moved_in = amt_ff - prod_ff;
         end else begin
            moved_in = '0;
         end
      end
      if (cmd.pool) begin
         below_in = pool_sum[NW] ? NIT_MAX : pool_sum[NW-1:0];
      end
      if (cmd.sum) begin
         below_in = below_ff - prod_ff;
         loss_in  = loss_sum[NW] ? NIT_MAX : loss_sum[NW-1:0];
      end
      if (cmd.finish) begin
         carry_in = last_ff ? '0 : moved_ff;
         acc_in   = acc_next;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      below_ff    <= below_in;
      prod_ff     <= prod_in;
      amt_ff      <= amt_in;
      strm_ff     <= strm_in;
      moved_ff    <= moved_in;
      loss_ff     <= loss_in;
      rem_ff      <= rem_in;
      dbits_ff    <= dbits_in;
      quot_ff     <= quot_in;
      last_ff     <= last_in;
      flux_pos_ff <= flux_pos_in;
      ovf_ff      <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
         acc_ff   <= '0;
      end else begin
         carry_ff <= carry_in;
         acc_ff   <= acc_in;
      end
   end

   assign sts.last = last_ff;

   assign result.new_layer_nitrate = n_ff;
   assign result.new_below_nitrate = last_ff ? below_ff : '0;
   assign result.leached_total     = loss_ff;
   assign result.stream_total      = acc_next;
   assign result.result_last       = last_ff;

endmodule
`default_nettype wire
